>>> rtl/mbps_pkg.sv
// Package for the masked byte pattern scanner.
// Holds the transaction types, configuration register indexes and sizes.
// No dependencies.
package mbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int LEN_W       = 5;
    localparam int ADDR_W      = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_item;

    typedef logic [PATTERN_MAX-1:0][7:0] t_window;

endpackage

>>> rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: first-match search with wildcards over a byte stream.
// Each result passes through the window register and then the output register,
// and holds at the output while i_out_stall is high.
// Throughput: one byte per cycle; the window compare over 16 positions is one
// combinational pass between the window register and the output register. The input
// stalls only while a byte that must answer waits behind a stalled output register.
// Reset: synchronous, active low; configuration returns to its reset values and the
// scanner starts a fresh region with an empty window.
module masked_byte_pattern_scanner (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbps_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbps_pkg::t_out_item               o_out_data
);
    import mbps_pkg::*;

    logic [ADDR_W-1:0]      r_region_base;
    logic [63:0]            r_pattern_low;
    logic [63:0]            r_pattern_high;
    logic [PATTERN_MAX-1:0] r_care_mask;
    logic [LEN_W-1:0]       r_pattern_length;

    t_window           r_window, n_window;
    logic [ADDR_W-1:0] r_bytes, n_bytes;
    logic              r_answer, n_answer;
    logic              r_clr, n_clr;
    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_active, n_s1_active;

    logic              r_out_valid;
    t_out_item         r_out_data;

    t_window           pattern;
    t_window           base_window;
    logic [LEN_W-1:0]  eff_len;
    logic              s1_match;
    logic              s1_emit;
    logic              s1_done;
    logic              out_free;
    logic              in_accept;
    logic              prev_ans;

    assign pattern  = {r_pattern_high, r_pattern_low};
    assign eff_len  = (r_pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                              : r_pattern_length;

    always_comb begin
        logic [LEN_W-1:0] idx;
        logic             ok;
        ok = (eff_len != '0) && (r_bytes >= ADDR_W'(eff_len));
        for (int i = 0; i < PATTERN_MAX; i++) begin
            idx = eff_len - LEN_W'(1) - LEN_W'(i);
            if ((LEN_W'(i) < eff_len) && r_care_mask[i]) begin
                if (pattern[i] != r_window[idx[LEN_W-2:0]]) begin
                    ok = 1'b0;
                end
            end
        end
        s1_match = ok;
    end

    assign s1_emit    = r_s1_active && (s1_match || r_clr);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_done    = r_s1_valid && (!s1_emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_done;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign base_window = r_clr ? '0 : r_window;
    assign prev_ans    = !r_clr && (r_answer || (r_s1_valid && r_s1_active && s1_match));

    always_comb begin
        n_window    = r_window;
        n_bytes     = r_bytes;
        n_answer    = r_answer;
        n_clr       = r_clr;
        n_s1_valid  = r_s1_valid;
        n_s1_active = r_s1_active;
        if (s1_done) begin
            n_s1_valid = 1'b0;
            if (r_s1_active && s1_match) begin
                n_answer = 1'b1;
            end
        end
        if (in_accept) begin
            n_answer    = prev_ans;
            n_s1_valid  = 1'b1;
            n_s1_active = !prev_ans;
            n_clr       = i_in_data.last_byte;
            if (!prev_ans) begin
                n_window = {base_window[PATTERN_MAX-2:0], i_in_data.data_byte};
                n_bytes  = (r_clr ? '0 : r_bytes) + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base    <= '0;
            r_pattern_low    <= '0;
            r_pattern_high   <= '0;
            r_care_mask      <= '0;
            r_pattern_length <= LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REGION_BASE:    r_region_base    <= i_cfg_wdata;
                CFG_PATTERN_LOW:    r_pattern_low    <= i_cfg_wdata;
                CFG_PATTERN_HIGH:   r_pattern_high   <= i_cfg_wdata;
                CFG_CARE_MASK:      r_care_mask      <= i_cfg_wdata[PATTERN_MAX-1:0];
                CFG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_window <= n_window;
        r_bytes  <= n_bytes;
        if (!i_rst_n) begin
            r_answer    <= 1'b0;
            r_clr       <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_s1_active <= 1'b0;
        end else begin
            r_answer    <= n_answer;
            r_clr       <= n_clr;
            r_s1_valid  <= n_s1_valid;
            r_s1_active <= n_s1_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_done && s1_emit;
        end
        if (out_free && s1_done && s1_emit) begin
            r_out_data.found         <= s1_match;
            r_out_data.match_address <= s1_match
                ? r_region_base + r_bytes - ADDR_W'(eff_len) : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> rtl/mbps_checker.sv
// Port-level checker for the masked byte pattern scanner, bound to the top level.
// Depends on mbps_pkg for the transaction types.
module mbps_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input mbps_pkg::t_out_item             o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result transaction changed");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.found |-> o_out_data.match_address == '0)
        else $error("not-found result carries a nonzero address");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while output side can move");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result transaction offered right after reset");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (.*);
